### sv/pmr_pkg.sv
// Package for the pointer motion rotator: widths, scale constants and the
// quarter-wave sine table.
// No dependencies; used by the top level, its checker and the testbench.
package pmr_pkg;

   // Field widths
   localparam int DeltaWidth  = 16;
   localparam int OutWidth    = 17;
   localparam int AngleWidth  = 10;
   localparam int TrigWidth   = 11;
   localparam int ProdWidth   = DeltaWidth + TrigWidth;   // product and sum of two products
   localparam int MagWidth    = ProdWidth - 1;            // magnitude of the sum
   localparam int QuotWidth   = 16;                       // |sum| / 1000 stays below 2^16

   // Rotation constants
   localparam int RotScale    = 1000;
   localparam int FullTurn    = 360;
   localparam int QuarterTurn = 90;
   localparam int TableLast   = 18;

   // Divide by 1000 as multiply by reciprocal, low by at most one
   localparam int RecipShift  = 36;
   localparam int RecipWidth  = 27;
   localparam logic [RecipWidth-1:0] RecipMult =
      RecipWidth'((64'd1 << RecipShift) / RotScale);

   // Index into the table: r / 5 as (r * 205) >> 10, exact for r < 90
   localparam int RemWidth    = 7;
   localparam int IdxMultWidth = 8;
   localparam logic [IdxMultWidth-1:0] IdxMult = 8'd205;
   localparam int IdxShift    = 10;
   localparam int IdxWidth    = 5;

   // Axis codes
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;

   typedef logic signed [TrigWidth-1:0] trig_type;

   // Sine of idx * 5 degrees, scaled by 1000
   function automatic trig_type pmr_sine(input logic [IdxWidth-1:0] idx);
      trig_type val;
      case (idx)
         5'd0:    val = 11'sd0;
         5'd1:    val = 11'sd87;
         5'd2:    val = 11'sd174;
         5'd3:    val = 11'sd259;
         5'd4:    val = 11'sd342;
         5'd5:    val = 11'sd423;
         5'd6:    val = 11'sd500;
         5'd7:    val = 11'sd574;
         5'd8:    val = 11'sd643;
         5'd9:    val = 11'sd707;
         5'd10:   val = 11'sd766;
         5'd11:   val = 11'sd819;
         5'd12:   val = 11'sd866;
         5'd13:   val = 11'sd906;
         5'd14:   val = 11'sd940;
         5'd15:   val = 11'sd966;
         5'd16:   val = 11'sd985;
         5'd17:   val = 11'sd996;
         5'd18:   val = 11'sd1000;
         default: val = 11'sd0;
      endcase
      return val;
   endfunction

endpackage

### sv/pointer_motion_rotator_unit.sv
// Pointer motion rotator top level: angle setup and the four-stage rotation pipeline.
// Depends on pmr_pkg.
//
// Rotates relative X/Y pointer deltas by a whole-degree angle written through
// csr_wr_en / csr_rotation_degrees; the write takes effect for items accepted from
// the next cycle on. The angle is reduced modulo 360 and rounded down to 5 degrees
// within its quadrant. Each item passes four register stages before it shows on
// rsp_valid: the two multiplies, the signed sum, a reciprocal multiply for the
// divide by 1000, and its one-step correction with the sign restore each end in
// a register of their own. The pipeline takes one item per cycle; it fills up
// behind a stalled result and holds req_stall only once every stage is occupied
// and the result is stalled. The stored last X and Y deltas update as items
// enter, so back-to-back items see their predecessors. Non-relative events and
// other axes come out unchanged in the same order.
module pointer_motion_rotator_unit
   import pmr_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic signed [AngleWidth-1:0] csr_rotation_degrees,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_is_relative,
   input  logic [1:0]                   req_axis,
   input  logic signed [DeltaWidth-1:0] req_delta,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [OutWidth-1:0]   rsp_delta_out
);

   // Angle setup
   logic signed [AngleWidth:0]   angle_wide;
   logic [AngleWidth-2:0]        angle_norm;
   logic [1:0]                   quad;
   logic [AngleWidth-2:0]        quad_base;
   logic [RemWidth-1:0]          angle_rem;
   logic [RemWidth+IdxMultWidth-1:0] idx_prod;
   logic [IdxWidth-1:0]          idx;
   trig_type                     tab_sin, tab_cos;
   trig_type                     sine_ff, cosine_ff, sine_in, cosine_in;

   // State and pipeline
   logic signed [DeltaWidth-1:0] last_x_ff, last_y_ff;
   logic                         rot_acc, is_x, is_y;
   logic signed [DeltaWidth-1:0] other_axis;

   logic                         s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   logic                         s1_rot_ff, s2_rot_ff, s3_rot_ff;
   logic                         s1_sub_ff;
   logic signed [DeltaWidth-1:0] s1_pass_ff, s2_pass_ff, s3_pass_ff;
   logic signed [ProdWidth-1:0]  s1_pcos_ff, s1_psin_ff, s1_pcos_in, s1_psin_in;
   logic signed [ProdWidth-1:0]  acc;
   logic                         s2_neg_ff, s3_neg_ff, s2_neg_in;
   logic [MagWidth-1:0]          s2_mag_ff, s3_mag_ff, s2_mag_in;
   logic [MagWidth+RecipWidth-1:0] recip_prod;
   logic [QuotWidth-1:0]         s3_quot_ff, s3_quot_in;
   logic [MagWidth-1:0]          quot_scaled, rem;
   logic [OutWidth-1:0]          quot_fix;
   logic signed [OutWidth-1:0]   rsp_delta_out_ff, rsp_delta_out_in;
   logic                         rdy_out, rdy3, rdy2, rdy1, accept;

   // Reduce the written angle into 0..359
   always_comb begin
      if (int'(csr_rotation_degrees) < -FullTurn) begin
         angle_wide = (AngleWidth+1)'(csr_rotation_degrees) + (AngleWidth+1)'(2 * FullTurn);
      end else if (csr_rotation_degrees < 0) begin
         angle_wide = (AngleWidth+1)'(csr_rotation_degrees) + (AngleWidth+1)'(FullTurn);
      end else if (int'(csr_rotation_degrees) >= FullTurn) begin
         angle_wide = (AngleWidth+1)'(csr_rotation_degrees) - (AngleWidth+1)'(FullTurn);
      end else begin
         angle_wide = (AngleWidth+1)'(csr_rotation_degrees);
      end
      angle_norm = angle_wide[AngleWidth-2:0];
   end

   // Split into quadrant and table index
   always_comb begin
      if (angle_norm >= 9'(3 * QuarterTurn)) begin
         quad = 2'd3;
      end else if (angle_norm >= 9'(2 * QuarterTurn)) begin
         quad = 2'd2;
      end else if (angle_norm >= 9'(QuarterTurn)) begin
         quad = 2'd1;
      end else begin
         quad = 2'd0;
      end
      case (quad)
         2'd0:    quad_base = 9'd0;
         2'd1:    quad_base = 9'(QuarterTurn);
         2'd2:    quad_base = 9'(2 * QuarterTurn);
         default: quad_base = 9'(3 * QuarterTurn);
      endcase
      angle_rem = RemWidth'(angle_norm - quad_base);
      idx_prod  = (RemWidth+IdxMultWidth)'(angle_rem) * (RemWidth+IdxMultWidth)'(IdxMult);
      idx       = idx_prod[IdxShift +: IdxWidth];
      tab_sin   = pmr_sine(idx);
      tab_cos   = pmr_sine(IdxWidth'(TableLast) - idx);
   end

   // Fold the quarter-wave values by quadrant
   always_comb begin
      case (quad)
         2'd0: begin
            sine_in   = tab_sin;
            cosine_in = tab_cos;
         end
         2'd1: begin
            sine_in   = tab_cos;
            cosine_in = -tab_sin;
         end
         2'd2: begin
            sine_in   = -tab_sin;
            cosine_in = -tab_cos;
         end
         default: begin
            sine_in   = -tab_cos;
            cosine_in = tab_sin;
         end
      endcase
   end

   // Hold the angle's sine and cosine; reset is angle zero
   always_ff @(posedge clock) begin
      if (reset) begin
         sine_ff   <= '0;
         cosine_ff <= TrigWidth'(RotScale);
      end else if (csr_wr_en) begin
         sine_ff   <= sine_in;
         cosine_ff <= cosine_in;
      end
   end

   // Stage handshakes: a stage advances when the one after it is empty or advancing
   assign rdy_out   = !rsp_valid_ff || !rsp_stall;
   assign rdy3      = !s3_valid_ff || rdy_out;
   assign rdy2      = !s2_valid_ff || rdy3;
   assign rdy1      = !s1_valid_ff || rdy2;
   assign req_stall = !rdy1;
   assign accept    = req_valid && rdy1;

   // Stage 1: classify the beat, form both products, record the raw delta
   assign is_x       = req_is_relative && (req_axis == AXIS_X);
   assign is_y       = req_is_relative && (req_axis == AXIS_Y);
   assign rot_acc    = is_x || is_y;
   assign other_axis = is_x ? last_y_ff : last_x_ff;
   assign s1_pcos_in = ProdWidth'(req_delta) * ProdWidth'(cosine_ff);
   assign s1_psin_in = ProdWidth'(other_axis) * ProdWidth'(sine_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         last_x_ff <= '0;
         last_y_ff <= '0;
      end else if (accept) begin
         if (is_x) begin
            last_x_ff <= req_delta;
         end
         if (is_y) begin
            last_y_ff <= req_delta;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_rot_ff  <= rot_acc;
         s1_sub_ff  <= is_x;
         s1_pass_ff <= req_delta;
         s1_pcos_ff <= s1_pcos_in;
         s1_psin_ff <= s1_psin_in;
      end
   end

   // Stage 2: signed sum, then split into sign and magnitude
   always_comb begin
      acc       = s1_sub_ff ? (s1_pcos_ff - s1_psin_ff) : (s1_pcos_ff + s1_psin_ff);
      s2_neg_in = acc[ProdWidth-1];
      s2_mag_in = s2_neg_in ? MagWidth'(-acc) : MagWidth'(acc);
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         s2_rot_ff  <= s1_rot_ff;
         s2_pass_ff <= s1_pass_ff;
         s2_neg_ff  <= s2_neg_in;
         s2_mag_ff  <= s2_mag_in;
      end
   end

   // Stage 3: estimate magnitude / 1000 by reciprocal multiply
   assign recip_prod = (MagWidth+RecipWidth)'(s2_mag_ff) * (MagWidth+RecipWidth)'(RecipMult);
   assign s3_quot_in = recip_prod[RecipShift +: QuotWidth];

   always_ff @(posedge clock) begin
      if (rdy3) begin
         s3_rot_ff  <= s2_rot_ff;
         s3_pass_ff <= s2_pass_ff;
         s3_neg_ff  <= s2_neg_ff;
         s3_mag_ff  <= s2_mag_ff;
         s3_quot_ff <= s3_quot_in;
      end
   end

   // Stage 4: correct the estimate by one, restore the sign, or pass the raw value
   always_comb begin
      quot_scaled = MagWidth'(s3_quot_ff) * MagWidth'(RotScale);
      rem         = s3_mag_ff - quot_scaled;
      quot_fix    = OutWidth'(s3_quot_ff) + OutWidth'(rem >= MagWidth'(RotScale));
      if (!s3_rot_ff) begin
         rsp_delta_out_in = OutWidth'(s3_pass_ff);
      end else if (s3_neg_ff) begin
         rsp_delta_out_in = -$signed(quot_fix);
      end else begin
         rsp_delta_out_in = $signed(quot_fix);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_out) begin
         rsp_delta_out_ff <= rsp_delta_out_in;
      end
   end

   // Advance the stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            s1_valid_ff <= req_valid;
         end
         if (rdy2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (rdy3) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (rdy_out) begin
            rsp_valid_ff <= s3_valid_ff;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_delta_out = rsp_delta_out_ff;

endmodule

### sv/pmr_checker.sv
// Port-level checker for the pointer motion rotator, bound to the top level.
// Depends on pmr_pkg and pointer_motion_rotator_unit.
module pmr_checker
   import pmr_pkg::*;
(
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic signed [OutWidth-1:0]   rsp_delta_out
);

   localparam int PipeDepth = 4;

   logic [2:0] pending_ff, pending_in;
   logic       req_beat, rsp_beat;

   // Count beats taken in but not yet delivered
   assign req_beat = req_valid && !req_stall;
   assign rsp_beat = rsp_valid && !rsp_stall;
   assign pending_in = pending_ff + 3'(req_beat) - 3'(rsp_beat);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // Output register empties on reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_delta_out))
      else $error("stalled result changed");

   // No result without a beat taken in
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 3'd0)
      else $error("result with no pending beat");

   // Never more beats in flight than pipeline stages
   a_depth: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 3'(PipeDepth))
      else $error("more beats in flight than stages");

   // Empty output stage never pushes back
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled while output is empty");

endmodule

bind pointer_motion_rotator_unit pmr_checker u_pmr_checker (.*);

### tb/tb_pointer_motion_rotator_unit.sv
// Self-checking testbench for pointer_motion_rotator_unit: drives motion beats and angle
// writes, predicts each rotated delta in-house and checks results in order.
// Depends on pmr_pkg and the pointer_motion_rotator_unit RTL.
module tb_pointer_motion_rotator_unit;
   import pmr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PipeDepth   = 4;
   localparam int StepDegrees = 5;
   localparam int MaxIdle     = 11;
   localparam int StallLimit  = 400;

   // Axis codes the block passes straight through
   localparam logic [1:0] AXIS_MISC_A = 2'd2;
   localparam logic [1:0] AXIS_MISC_B = 2'd3;

   typedef enum int {QUAD_I, QUAD_II, QUAD_III, QUAD_IV} quadrant_type;

   // Sine of 0..90 degrees in 5-degree steps, scaled by 1000
   localparam int SineByStep [0:TableLast] = '{
      0, 87, 174, 259, 342, 423, 500, 574, 643, 707,
      766, 819, 866, 906, 940, 966, 985, 996, 1000
   };

   logic                         clock;
   logic                         reset = 1'b1;
   logic                         csr_wr_en = 1'b0;
   logic signed [AngleWidth-1:0] csr_rotation_degrees = '0;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic                         req_is_relative = 1'b0;
   logic [1:0]                   req_axis = AXIS_X;
   logic signed [DeltaWidth-1:0] req_delta = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic signed [OutWidth-1:0]   rsp_delta_out;

   pointer_motion_rotator_unit u_dut (
      .clock                (clock),
      .reset                (reset),
      .csr_wr_en            (csr_wr_en),
      .csr_rotation_degrees (csr_rotation_degrees),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_is_relative      (req_is_relative),
      .req_axis             (req_axis),
      .req_delta            (req_delta),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_delta_out        (rsp_delta_out)
   );

   // Predicted rotator state
   logic signed [DeltaWidth-1:0] held_x = '0;
   logic signed [DeltaWidth-1:0] held_y = '0;
   trig_type                     sine_now = 11'sd0;
   trig_type                     cosine_now = 11'sd1000;

   logic signed [OutWidth-1:0]   expected_deltas [$];
   int                           mismatches = 0;
   int                           beats_in = 0;
   int                           beats_out = 0;
   int                           angles_set = 0;
   int                           sink_hold = 0;
   int                           quiet_cycles = 0;
   bit                           sender_idles = 1'b1;
   bit                           sink_idles = 1'b1;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Reload sine and cosine for a new angle
   function automatic void aim_angle(input logic signed [AngleWidth-1:0] deg);
      int       turn;
      int       step;
      trig_type s;
      trig_type c;
      turn = int'(deg) % FullTurn;
      if (turn < 0) turn += FullTurn;
      step = (turn % QuarterTurn) / StepDegrees;
      s = trig_type'(SineByStep[step]);
      c = trig_type'(SineByStep[TableLast - step]);
      case (quadrant_type'(turn / QuarterTurn))
         QUAD_I: begin
            sine_now = s;   cosine_now = c;
         end
         QUAD_II: begin
            sine_now = c;   cosine_now = -s;
         end
         QUAD_III: begin
            sine_now = -s;  cosine_now = -c;
         end
         default: begin
            sine_now = -c;  cosine_now = s;
         end
      endcase
   endfunction

   // Rotated delta for one beat; store the raw value of its axis
   function automatic logic signed [OutWidth-1:0] rotate_motion(
         input logic rel, input logic [1:0] ax, input logic signed [DeltaWidth-1:0] d);
      longint                     acc;
      logic signed [OutWidth-1:0] res;
      res = d;
      if (rel && ax == AXIS_X) begin
         acc = longint'(d) * cosine_now - longint'(held_y) * sine_now;
         res = OutWidth'(acc / RotScale);
         held_x = d;
      end else if (rel && ax == AXIS_Y) begin
         acc = longint'(held_x) * sine_now + longint'(d) * cosine_now;
         res = OutWidth'(acc / RotScale);
         held_y = d;
      end
      return res;
   endfunction

   function automatic logic signed [DeltaWidth-1:0] pick_delta();
      case ($urandom_range(0, 9))
         0:       return 16'sh7fff;
         1:       return 16'sh8000;
         2:       return DeltaWidth'($urandom_range(0, 20)) - 16'sd10;
         default: return DeltaWidth'($urandom);
      endcase
   endfunction

   // Send one beat, after a random gap if the sender idles; hold it until accepted
   task automatic send_motion(input logic rel, input logic [1:0] ax,
                              input logic signed [DeltaWidth-1:0] d);
      int gap;
      gap = sender_idles ? $urandom_range(0, MaxIdle) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_is_relative <= rel;
      req_axis        <= ax;
      req_delta       <= d;
      do @(posedge clock); while (req_stall);
      expected_deltas.push_back(rotate_motion(rel, ax, d));
      beats_in++;
   endtask

   // Mostly relative X/Y motion, some pass-through noise
   task automatic send_random_motion();
      logic       rel;
      logic [1:0] ax;
      if ($urandom_range(0, 19) < 17) begin
         rel = 1'b1;
         ax  = $urandom_range(0, 1) ? AXIS_Y : AXIS_X;
      end else begin
         rel = 1'($urandom_range(0, 1));
         ax  = 2'($urandom_range(0, 3));
      end
      send_motion(rel, ax, pick_delta());
   endtask

   // Drop valid and wait until the pipeline is empty
   task automatic settle_pipeline();
      req_valid <= 1'b0;
      wait (expected_deltas.size() == 0);
      repeat (PipeDepth + 2) @(posedge clock);
   endtask

   task automatic write_angle(input logic signed [AngleWidth-1:0] deg);
      settle_pipeline();
      csr_wr_en            <= 1'b1;
      csr_rotation_degrees <= deg;
      @(posedge clock);
      aim_angle(deg);
      angles_set++;
      csr_wr_en <= 1'b0;
   endtask

   // Angle zero out of reset: identity, pass-through codes, full-scale deltas
   task automatic test_reset_state();
      send_motion(1'b1, AXIS_X, 16'sh7fff);
      send_motion(1'b1, AXIS_Y, 16'sh8000);
      send_motion(1'b0, AXIS_X, 16'sd123);
      send_motion(1'b1, AXIS_MISC_A, 16'sh7fff);
      send_motion(1'b1, AXIS_MISC_B, 16'sh8000);
      send_motion(1'b0, AXIS_MISC_B, -16'sd5);
      send_motion(1'b1, AXIS_X, -16'sd1);
   endtask

   // Range ends, out-of-range codes, step truncation and quadrant borders
   task automatic test_angle_extremes();
      logic signed [AngleWidth-1:0] angles [9];
      angles = '{-10'sd359, 10'sd359, 10'sh200, 10'sd511, 10'sd4,
                 10'sd45, 10'sd90, 10'sd180, 10'sd270};
      foreach (angles[i]) begin
         write_angle(angles[i]);
         send_motion(1'b1, AXIS_X, i[0] ? 16'sh8000 : 16'sh7fff);
         send_motion(1'b1, AXIS_Y, i[0] ? 16'sh7fff : 16'sh8000);
      end
   endtask

   // Random angles, each followed by a run of random motion
   task automatic test_random_rotation();
      logic signed [AngleWidth-1:0] deg;
      repeat (26) begin
         if ($urandom_range(0, 3) == 0) deg = AngleWidth'($urandom);
         else deg = AngleWidth'($urandom_range(0, 718)) - 10'sd359;
         write_angle(deg);
         sender_idles = ($urandom_range(0, 4) != 0);
         sink_idles   = ($urandom_range(0, 4) != 0);
         repeat (50) send_random_motion();
      end
      sender_idles = 1'b1;
      sink_idles   = 1'b1;
   endtask

   // Back-to-back beats with an always-ready sink
   task automatic test_streaming();
      write_angle(AngleWidth'($urandom_range(0, 359)));
      sender_idles = 1'b0;
      sink_idles   = 1'b0;
      repeat (300) send_random_motion();
      sender_idles = 1'b1;
      sink_idles   = 1'b1;
   endtask

   // Pause the sender until every result is back, several times
   task automatic test_drain_pause();
      write_angle(-AngleWidth'($urandom_range(1, 359)));
      repeat (5) begin
         repeat (50) send_random_motion();
         settle_pipeline();
      end
   endtask

   // Result side: check each accepted beat and draw the next stall
   always @(posedge clock) begin
      if (reset) begin
         sink_hold = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            beats_out++;
            if (expected_deltas.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result delta_out=%0d", $time, rsp_delta_out);
            end else begin
               if (rsp_delta_out !== expected_deltas[0]) begin
                  mismatches++;
                  $display("%0t: delta_out expected %0d, actual %0d",
                           $time, expected_deltas[0], rsp_delta_out);
               end
               void'(expected_deltas.pop_front());
            end
            sink_hold = sink_idles ? $urandom_range(0, MaxIdle) : 0;
         end else if (sink_hold > 0) begin
            sink_hold--;
         end
         rsp_stall <= (sink_hold > 0);
      end
   end

   // Watchdog: end the run after too long with no beat moving
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en || reset)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
         $display("%0t: no progress for %0d cycles", $time, StallLimit);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_angle_extremes();
      test_random_rotation();
      test_streaming();
      test_drain_pause();
      settle_pipeline();
      repeat (2 * PipeDepth) @(posedge clock);
      $display("Run covered %0d beats in, %0d out, over %0d angle writes,", beats_in,
               beats_out, angles_set);
      $display("incl. full-scale deltas, pass-through codes and out-of-range angles.");
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

### pointer_motion_rotator_unit.f
sv/pmr_pkg.sv
sv/pointer_motion_rotator_unit.sv
sv/pmr_checker.sv
tb/tb_pointer_motion_rotator_unit.sv
